/* sv/ifbs_pkg.sv */
// ----------------------------------------------------------------------------
// Interleaved file broadcast scheduler package
// Shared widths, register indices and the structs passed between modules.
// ----------------------------------------------------------------------------
package ifbs_pkg;

  localparam int unsigned ID_W      = 31;
  localparam int unsigned TICK_W    = 16;
  localparam int unsigned PORT_W    = 3;
  localparam int unsigned EN_W      = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 31;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 40;

  // Configuration register indices
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_ID     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_ID      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELOAD_TICKS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PORT_ENABLE  = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0]   first_id;
    logic [ID_W-1:0]   last_id;
    logic [TICK_W-1:0] reload_ticks;
    logic [EN_W-1:0]   port_enable;
  } cfg_t;

  typedef struct packed {
    logic              transfer_more;
    logic              carrier_busy;
    logic [TICK_W-1:0] elapsed_ticks;
    logic [PORT_W-1:0] port;
  } item_t;

  typedef struct packed {
    logic            from_recent;
    logic [ID_W-1:0] chosen_id;
    logic            start_new;
    logic            continue_round;
  } result_t;

endpackage

/* sv/interleaved_file_broadcast_scheduler.sv */
// ----------------------------------------------------------------------------
// Interleaved file broadcast scheduler
// Services one port per transaction and decides rounds and new files.
// ----------------------------------------------------------------------------
// Usage:
// Each transaction on the s_axis channel services one port and yields
// exactly one result on the m_axis channel: whether a round of the ongoing
// transfer is sent, and whether a new file starts together with its id and
// whether it came from the backward walk over the newest ids.
// The cfg channel writes the id range, reload delay and port enables; it is
// always ready and should be written only while the block is idle.
// An accepted item is held in an input register. Once the result register is
// free or being taken, the per-port state is read and updated and the result
// registered. One item per cycle is sustained while the receiver does not
// stall, set by the read-modify-write of the per-port state registers.
// Reset clears all per-port state and loads the register defaults (first id
// one, last id zero, so no files). When the receiver stalls, the result
// register holds and the input register fills; s_axis_tready_o then falls.
// ----------------------------------------------------------------------------
module interleaved_file_broadcast_scheduler
  import ifbs_pkg::*;
#(
  parameter int unsigned NUM_PORTS     = 8,
  parameter int unsigned RECENT_WINDOW = 200
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // port[2:0], elapsed_ticks[18:3], carrier_busy[19], transfer_more[20]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // continue_round[0], start_new[1], chosen_id[32:2], from_recent[33]
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_W-1:0]      cfg_data_i
);

  cfg_t    cfg;
  item_t   item_q;
  result_t result, out_q;
  logic    in_vld_q, out_vld_q, out_vld_d, advance;

  assign cfg_ready_o = 1'b1;

  ifbs_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign advance         = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || advance;
  assign out_vld_d       = advance || (out_vld_q && !m_axis_tready_i);

  ifbs_sched #(
    .NUM_PORTS     (NUM_PORTS),
    .RECENT_WINDOW (RECENT_WINDOW)
  ) u_sched (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .update_i (advance),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        in_vld_q <= s_axis_tvalid_i;
      end
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      item_q <= item_t'(s_axis_tdata_i[$bits(item_t)-1:0]);
    end
    if (advance) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {(OUT_DATA_W - $bits(result_t))'(0), out_q};

`ifndef SYNTH
  a_recent_needs_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.from_recent |-> out_q.start_new)
    else $error("result marked as recent without a new transfer");

  a_id_zero_unless_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_q.start_new |-> out_q.chosen_id == '0)
    else $error("chosen id non-zero without a new transfer");

  a_stall_holds_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !advance |=> in_vld_q && $stable(item_q))
    else $error("held input item lost while the result side stalled");

  a_advance_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_vld_q)
    else $error("processed item did not reach the result register");
`endif

endmodule

/* sv/ifbs_cfg.sv */
// ----------------------------------------------------------------------------
// Scheduler configuration registers
// Holds the id range, reload delay and per-port enable bits.
// ----------------------------------------------------------------------------
module ifbs_cfg
  import ifbs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_FIRST_ID:     cfg_d.first_id     = cfg_data_i[ID_W-1:0];
        REG_LAST_ID:      cfg_d.last_id      = cfg_data_i[ID_W-1:0];
        REG_RELOAD_TICKS: cfg_d.reload_ticks = cfg_data_i[TICK_W-1:0];
        REG_PORT_ENABLE:  cfg_d.port_enable  = cfg_data_i[EN_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_id     <= ID_W'(1);
      cfg_q.last_id      <= '0;
      cfg_q.reload_ticks <= '0;
      cfg_q.port_enable  <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* sv/ifbs_sched.sv */
// ----------------------------------------------------------------------------
// Scheduler per-port state and decision logic
// Reads the serviced port's state, decides the round and the next file, and
// writes the state back when the transaction moves to the result register.
// ----------------------------------------------------------------------------
module ifbs_sched
  import ifbs_pkg::*;
#(
  parameter int unsigned NUM_PORTS     = 8,
  parameter int unsigned RECENT_WINDOW = 200
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    update_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t result_o
);

  localparam int unsigned IDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam int unsigned SW    = ID_W + 2;
  localparam logic signed [SW-1:0] WIN = SW'(RECENT_WINDOW);

  logic              active_q   [NUM_PORTS];
  logic              turn_q     [NUM_PORTS];
  logic              ptr_vld_q  [NUM_PORTS];
  logic [ID_W-1:0]   sweep_q    [NUM_PORTS];
  logic [ID_W-1:0]   recent_q   [NUM_PORTS];
  logic [TICK_W-1:0] delay_q    [NUM_PORTS];

  logic [IDX_W-1:0] idx;
  logic             in_range, go, fire, active_after, choose, cont, turn, many;
  logic signed [SW-1:0] first_s, last_s, sweep_base, recent_base;
  logic signed [SW-1:0] sweep_inc, sweep_new, recent_dec, recent_new;

  assign in_range = {1'b0, item_i.port} < (PORT_W + 1)'(NUM_PORTS);
  assign idx      = IDX_W'(item_i.port);
  assign go       = in_range && (cfg_i.last_id >= cfg_i.first_id)
                    && cfg_i.port_enable[item_i.port] && !item_i.carrier_busy;

  assign fire         = delay_q[idx] <= item_i.elapsed_ticks;
  assign cont         = fire && active_q[idx];
  assign active_after = active_q[idx] && item_i.transfer_more;
  assign choose       = fire && !active_after;
  assign turn         = turn_q[idx];

  assign first_s = $signed({2'b00, cfg_i.first_id});
  assign last_s  = $signed({2'b00, cfg_i.last_id});
  assign many    = (last_s - first_s) > WIN;

  // Before the first choice the sweep sits just below the range and the
  // backward walk at the newest id.
  assign sweep_base  = ptr_vld_q[idx] ? $signed({2'b00, sweep_q[idx]}) : first_s - SW'(1);
  assign recent_base = ptr_vld_q[idx] ? $signed({2'b00, recent_q[idx]}) : last_s;

  assign sweep_inc  = sweep_base + SW'(1);
  assign sweep_new  = (sweep_inc > last_s || sweep_inc < first_s) ? first_s : sweep_inc;
  assign recent_dec = recent_base - SW'(1);
  assign recent_new = (recent_dec < last_s - WIN || recent_dec < first_s) ? last_s
                                                                          : recent_dec;

  always_comb begin
    result_o = '0;
    if (go) begin
      result_o.continue_round = cont;
      if (choose) begin
        result_o.start_new   = 1'b1;
        result_o.from_recent = turn;
        result_o.chosen_id   = turn ? recent_new[ID_W-1:0] : sweep_new[ID_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PORTS; i++) begin
        active_q[i]  <= 1'b0;
        turn_q[i]    <= 1'b0;
        ptr_vld_q[i] <= 1'b0;
        sweep_q[i]   <= '0;
        recent_q[i]  <= '0;
        delay_q[i]   <= '0;
      end
    end else if (update_i && go) begin
      if (fire) begin
        active_q[idx] <= choose ? 1'b1 : active_after;
        delay_q[idx]  <= cfg_i.reload_ticks;
        if (choose) begin
          ptr_vld_q[idx] <= 1'b1;
          if (turn) begin
            turn_q[idx]   <= 1'b0;
            sweep_q[idx]  <= sweep_base[ID_W-1:0];
            recent_q[idx] <= recent_new[ID_W-1:0];
          end else begin
            turn_q[idx]   <= many;
            sweep_q[idx]  <= sweep_new[ID_W-1:0];
            recent_q[idx] <= recent_base[ID_W-1:0];
          end
        end
      end else begin
        delay_q[idx] <= delay_q[idx] - item_i.elapsed_ticks;
      end
    end
  end

endmodule

/* dv/tb_interleaved_file_broadcast_scheduler.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the interleaved file broadcast scheduler
// Drives service passes through the input stream and checks every result
// against a scoreboard that tracks the per-port transfer, delay and pointer
// state. A directed opening covers skipped passes, round ends, pointer wrap
// and the id extremes. Randomised phases then follow, each with its own
// register setting, including a long run on one port that walks the recent
// window all the way round.
// ----------------------------------------------------------------------------
module tb_interleaved_file_broadcast_scheduler;
  import ifbs_pkg::*;

  localparam int unsigned NUM_PORTS     = 8;
  localparam int unsigned RECENT_WINDOW = 200;
  localparam int unsigned STALL_LIMIT   = 20000;
  localparam int unsigned ITEM_W        = $bits(item_t);
  localparam int unsigned RESULT_W      = $bits(result_t);

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  // port[2:0], elapsed_ticks[18:3], carrier_busy[19], transfer_more[20]
  logic [IN_DATA_W-1:0]  s_axis_tdata_i  = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  // continue_round[0], start_new[1], chosen_id[32:2], from_recent[33]
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                  cfg_valid_i     = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i     = REG_FIRST_ID;
  logic [CFG_W-1:0]      cfg_data_i      = '0;

  // Register shadow, written at each configuration transaction.
  logic [ID_W-1:0]   cfg_first  = 31'd1;
  logic [ID_W-1:0]   cfg_last   = 31'd0;
  logic [TICK_W-1:0] cfg_reload = '0;
  logic [EN_W-1:0]   cfg_enable = '0;

  // Per-port scheduler state as the block should hold it.
  logic              busy_xfer  [NUM_PORTS];
  logic              recent_due [NUM_PORTS];
  logic              ptrs_loaded[NUM_PORTS];
  logic [ID_W-1:0]   sweep_at   [NUM_PORTS];
  logic [ID_W-1:0]   recent_at  [NUM_PORTS];
  logic [TICK_W-1:0] ticks_left [NUM_PORTS];

  item_t       service_queue[$];
  result_t     results_due[$];
  int unsigned mismatches   = 0;
  int unsigned src_idle_pct = 15;
  int unsigned dst_idle_pct = 85;
  int unsigned stall_cycles = 0;

  interleaved_file_broadcast_scheduler #(
    .NUM_PORTS    (NUM_PORTS),
    .RECENT_WINDOW(RECENT_WINDOW)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    for (int p = 0; p < NUM_PORTS; p++) begin
      busy_xfer[p]   = 1'b0;
      recent_due[p]  = 1'b0;
      ptrs_loaded[p] = 1'b0;
      sweep_at[p]    = '0;
      recent_at[p]   = '0;
      ticks_left[p]  = '0;
    end
  end

  // One service pass: returns the expected result and advances the port state.
  function automatic result_t schedule_pass(input item_t it);
    result_t r;
    longint  lo;
    longint  hi;
    longint  sw;
    longint  rc;
    int      p;
    r  = '0;
    p  = it.port;
    lo = {33'd0, cfg_first};
    hi = {33'd0, cfg_last};
    if (p >= NUM_PORTS || hi < lo || !cfg_enable[p] || it.carrier_busy) return r;
    if (ticks_left[p] <= it.elapsed_ticks) begin
      if (busy_xfer[p]) begin
        r.continue_round = 1'b1;
        busy_xfer[p]     = it.transfer_more;
      end
      if (!busy_xfer[p]) begin
        if (ptrs_loaded[p]) begin
          sw = {33'd0, sweep_at[p]};
          rc = {33'd0, recent_at[p]};
        end else begin
          sw = lo - 1;
          rc = hi;
          ptrs_loaded[p] = 1'b1;
        end
        if (recent_due[p]) begin
          rc = rc - 1;
          if (rc < hi - RECENT_WINDOW) rc = hi;
          if (rc < lo) rc = hi;
          recent_due[p] = 1'b0;
          r.chosen_id   = rc[ID_W-1:0];
          r.from_recent = 1'b1;
        end else begin
          sw = sw + 1;
          if (sw > hi) sw = lo;
          if (sw < lo) sw = lo;
          if (hi - lo > RECENT_WINDOW) recent_due[p] = 1'b1;
          r.chosen_id = sw[ID_W-1:0];
        end
        sweep_at[p]  = sw[ID_W-1:0];
        recent_at[p] = rc[ID_W-1:0];
        busy_xfer[p] = 1'b1;
        r.start_new  = 1'b1;
      end
      ticks_left[p] = cfg_reload;
    end else begin
      ticks_left[p] = ticks_left[p] - it.elapsed_ticks;
    end
    return r;
  endfunction

  function automatic item_t pass_item(input logic [PORT_W-1:0] port,
                                      input logic [TICK_W-1:0] elapsed,
                                      input logic carrier, input logic more);
    item_t it;
    it.port          = port;
    it.elapsed_ticks = elapsed;
    it.carrier_busy  = carrier;
    it.transfer_more = more;
    return it;
  endfunction

  // With one_port, a run mostly on port 0 with transfers ending at once, so the backward
  // walk is chosen often enough to wrap round the window; else any port, random carrier.
  function automatic item_t random_item(input bit one_port);
    item_t       it;
    int unsigned pick;
    it.port = (one_port && $urandom_range(19) != 0) ? 3'd0 : 3'($urandom_range(7));
    pick = $urandom_range(9);
    if (pick < 5)      it.elapsed_ticks = 16'($urandom_range(8));
    else if (pick < 8) it.elapsed_ticks = 16'($urandom);
    else if (pick == 8) it.elapsed_ticks = 16'hFFFF;
    else               it.elapsed_ticks = 16'h0000;
    it.carrier_busy  = !one_port && $urandom_range(9) == 0;
    it.transfer_more = one_port ? ($urandom_range(29) == 0) : 1'($urandom_range(1));
    return it;
  endfunction

  task automatic set_config(input logic [ID_W-1:0] first, input logic [ID_W-1:0] last,
                            input logic [TICK_W-1:0] reload, input logic [EN_W-1:0] enable);
    cfg_valid_i <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      case (i)
        0: begin
          cfg_index_i <= REG_FIRST_ID;
          cfg_data_i  <= first;
        end
        1: begin
          cfg_index_i <= REG_LAST_ID;
          cfg_data_i  <= last;
        end
        2: begin
          cfg_index_i <= REG_RELOAD_TICKS;
          cfg_data_i  <= CFG_W'(reload);
        end
        default: begin
          cfg_index_i <= REG_PORT_ENABLE;
          cfg_data_i  <= CFG_W'(enable);
        end
      endcase
      do @(posedge clk_i); while (!cfg_ready_o);
      case (i)
        0: cfg_first = first;
        1: cfg_last = last;
        2: cfg_reload = reload;
        default: cfg_enable = enable;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Waits until every queued item has been sent and every pending result has been taken.
  task automatic wait_idle();
    do @(posedge clk_i);
    while (service_queue.size() != 0 || s_axis_tvalid_i || results_due.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Driver: a new item is offered once the previous one has gone.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o)
        results_due.push_back(schedule_pass(item_t'(s_axis_tdata_i[ITEM_W-1:0])));
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (service_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= IN_DATA_W'(service_queue.pop_front());
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= dst_idle_pct);
  end

  // Monitor: each result transaction is held against the oldest expectation.
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    got = result_t'(m_axis_tdata_o[RESULT_W-1:0]);
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        mismatches++;
      end else begin
        want = results_due.pop_front();
        if (got.continue_round !== want.continue_round) begin
          $display("%0t: continue_round expected %0d actual %0d",
                   $time, want.continue_round, got.continue_round);
          mismatches++;
        end
        if (got.start_new !== want.start_new) begin
          $display("%0t: start_new expected %0d actual %0d",
                   $time, want.start_new, got.start_new);
          mismatches++;
        end
        if (got.chosen_id !== want.chosen_id) begin
          $display("%0t: chosen_id expected %0d actual %0d",
                   $time, want.chosen_id, got.chosen_id);
          mismatches++;
        end
        if (got.from_recent !== want.from_recent) begin
          $display("%0t: from_recent expected %0d actual %0d",
                   $time, want.from_recent, got.from_recent);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    logic [ID_W-1:0]   first;
    logic [ID_W-1:0]   last;
    logic [TICK_W-1:0] reload;
    logic [EN_W-1:0]   enable;
    int unsigned       kind;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset values leave the id range empty and every port disabled.
    service_queue.push_back(pass_item(3'd0, 16'h0000, 1'b0, 1'b0));
    service_queue.push_back(pass_item(3'd7, 16'hFFFF, 1'b0, 1'b1));
    wait_idle();

    // Four files, port 6 disabled: delay countdown, rounds and sweep wrap.
    set_config(31'd5, 31'd8, 16'd2, 8'hBF);
    service_queue.push_back(pass_item(3'd6, 16'hFFFF, 1'b0, 1'b0));
    service_queue.push_back(pass_item(3'd0, 16'h0000, 1'b1, 1'b1));
    service_queue.push_back(pass_item(3'd0, 16'h0000, 1'b0, 1'b0));
    service_queue.push_back(pass_item(3'd0, 16'h0001, 1'b0, 1'b0));
    service_queue.push_back(pass_item(3'd0, 16'h0001, 1'b0, 1'b1));
    service_queue.push_back(pass_item(3'd0, 16'hFFFF, 1'b0, 1'b0));
    for (int i = 0; i < 5; i++)
      service_queue.push_back(pass_item(3'd1, 16'hFFFF, 1'b0, 1'b0));
    wait_idle();

    // More files than the window, so the backward walk takes every second turn.
    set_config(31'd0, 31'd300, 16'd0, 8'hFF);
    for (int i = 0; i < 4; i++)
      service_queue.push_back(pass_item(3'd2, 16'h0000, 1'b0, 1'b0));
    service_queue.push_back(pass_item(3'd0, 16'h0000, 1'b0, 1'b0));
    wait_idle();

    set_config(31'd0, 31'h7FFF_FFFF, 16'hFFFF, 8'h80);
    service_queue.push_back(pass_item(3'd7, 16'hFFFF, 1'b0, 1'b0));
    service_queue.push_back(pass_item(3'd7, 16'hFFFE, 1'b0, 1'b0));
    service_queue.push_back(pass_item(3'd7, 16'h0001, 1'b0, 1'b0));
    service_queue.push_back(pass_item(3'd3, 16'hFFFF, 1'b0, 1'b0));
    wait_idle();

    set_config(31'h7FFF_FFFF, 31'h7FFF_FFFF, 16'd0, 8'h81);
    service_queue.push_back(pass_item(3'd7, 16'h0000, 1'b0, 1'b0));
    service_queue.push_back(pass_item(3'd7, 16'h0000, 1'b0, 1'b0));
    wait_idle();

    // A last id below the first id means no files at all.
    set_config(31'd10, 31'd9, 16'd0, 8'hFF);
    service_queue.push_back(pass_item(3'd4, 16'hFFFF, 1'b0, 1'b0));
    wait_idle();

    for (int phase = 0; phase < 10; phase++) begin
      if (phase < 3) begin
        src_idle_pct = 15;
        dst_idle_pct = 85;
      end else if (phase < 6) begin
        src_idle_pct = 85;
        dst_idle_pct = 15;
      end else begin
        src_idle_pct = 0;
        dst_idle_pct = 0;
      end
      if (phase == 6) begin
        set_config(31'd100, 31'd305, 16'd0, 8'h01 | 8'($urandom));
        for (int i = 0; i < 500; i++) service_queue.push_back(random_item(1'b1));
      end else begin
        kind = $urandom_range(9);
        if (kind < 3) begin
          first = 31'($urandom_range(1000));
          last  = first + 31'($urandom_range(10));
        end else if (kind < 6) begin
          first = 31'($urandom_range(1000));
          last  = first + 31'($urandom_range(260, 190));
        end else if (kind == 6) begin
          first = $urandom_range(1) ? 31'd0 : 31'($urandom_range(1000));
          last  = 31'h7FFF_FFFF;
        end else if (kind == 7) begin
          first = 31'($urandom_range(1000, 1));
          last  = first - 31'd1;
        end else begin
          // Shifted range: stale pointers fall below the new first id or
          // out of the new window.
          first = cfg_first + 31'($urandom_range(50));
          last  = cfg_last + 31'($urandom_range(300));
        end
        kind = $urandom_range(9);
        if (kind == 0)      reload = 16'h0000;
        else if (kind == 1) reload = 16'hFFFF;
        else                reload = 16'($urandom_range(15));
        enable = ($urandom_range(2) == 0) ? 8'hFF : 8'($urandom);
        set_config(first, last, reload, enable);
        for (int i = 0; i < 125; i++) service_queue.push_back(random_item(1'b0));
      end
      wait_idle();
    end

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
